// ----- design/rdsc_pkg.sv -----
package rdsc_pkg;

  localparam int unsigned MAX_ENTRIES = 8;

  localparam int unsigned COUNT_W = 4;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned SCAN_W  = 8;
  localparam int unsigned FOCUS_W = 16;
  localparam int unsigned CLICK_W = 10;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_PERIOD   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCUS_HOLD    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_LOCKOUT = 2'd3;

  // step codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_BWD  = 2'd2;

  // quadrature phases, {a, b}
  localparam logic [1:0] PHASE_00 = 2'b00;
  localparam logic [1:0] PHASE_01 = 2'b01;
  localparam logic [1:0] PHASE_10 = 2'b10;
  localparam logic [1:0] PHASE_11 = 2'b11;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST   = 4'd0;
  localparam logic [SCAN_W-1:0]  SCAN_PERIOD_RST   = 8'd8;
  localparam logic [FOCUS_W-1:0] FOCUS_HOLD_RST    = 16'd5000;
  localparam logic [CLICK_W-1:0] CLICK_LOCKOUT_RST = 10'd350;

endpackage

// ----- design/rotary_dial_selection_controller.sv -----
// channel | dir | handshake            | payload
// s_*     | in  | s_tvalid / s_tready  | s_tdata: pin_a, pin_b, key_level
// m_*     | out | m_tvalid / m_tready  | m_tdata: selected_index .. poke_valid
// cfg_*   | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one result per tick: the tick is decoded in a single
// combinational pass and lands in the output register at the accepting edge.
// a new tick is taken every cycle while the output register is empty or drained.
// rst is synchronous, active high; it restores all registers but m_tdata to their reset values.
// a stall on m_tready holds the result and blocks s_tready; cfg writes are always taken.
module rotary_dial_selection_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [0] pin_a, [1] pin_b, [2] key_level, [7:3] zero
  input  logic [rdsc_pkg::IN_TDATA_W-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [2:0] selected_index, [3] focus_active, [5:4] step_code, [6] leave_valid,
  // [9:7] leave_index, [10] open_valid, [11] poke_valid, [15:12] zero
  output logic [rdsc_pkg::OUT_TDATA_W-1:0]      m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rdsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rdsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration
  logic [rdsc_pkg::COUNT_W-1:0] entry_count;
  logic [rdsc_pkg::SCAN_W-1:0]  scan_period;
  logic [rdsc_pkg::FOCUS_W-1:0] focus_hold;
  logic [rdsc_pkg::CLICK_W-1:0] click_lockout;

  // state
  logic [1:0]                   last_phase, last_phase_next;
  logic [1:0]                   pending_step, pending_step_next;
  logic                         key_was_down, key_was_down_next;
  logic [rdsc_pkg::INDEX_W-1:0] selection, selection_next;
  logic [rdsc_pkg::FOCUS_W-1:0] focus_left, focus_left_next;
  logic [rdsc_pkg::CLICK_W-1:0] since_click, since_click_next;
  logic [rdsc_pkg::SCAN_W-1:0]  since_scan, since_scan_next;
  logic                         focus_reported, focus_reported_next;

  logic [rdsc_pkg::OUT_TDATA_W-1:0] result_next;
  logic                             in_fire;

  logic [rdsc_pkg::COUNT_W-1:0] count;
  logic [rdsc_pkg::COUNT_W-1:0] cfg_count;
  logic [rdsc_pkg::INDEX_W-1:0] last_index;
  logic                         cfg_clamp;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign count      = (entry_count > rdsc_pkg::COUNT_W'(rdsc_pkg::MAX_ENTRIES))
                      ? rdsc_pkg::COUNT_W'(rdsc_pkg::MAX_ENTRIES) : entry_count;
  assign last_index = rdsc_pkg::INDEX_W'(count - 4'd1);

  always_comb begin
    cfg_count = cfg_data[rdsc_pkg::COUNT_W-1:0];
    if (cfg_count > rdsc_pkg::COUNT_W'(rdsc_pkg::MAX_ENTRIES)) begin
      cfg_count = rdsc_pkg::COUNT_W'(rdsc_pkg::MAX_ENTRIES);
    end
  end

  assign cfg_clamp = cfg_valid && cfg_ready && (cfg_index == rdsc_pkg::REG_ENTRY_COUNT)
                     && (rdsc_pkg::COUNT_W'(selection) >= cfg_count);

  always_comb begin
    logic [1:0]                   phase;
    logic                         key_down;
    logic [1:0]                   step;
    logic                         leave;
    logic [rdsc_pkg::INDEX_W-1:0] leave_idx;
    logic                         open;
    logic                         poke;
    logic                         focused;

    phase     = {s_tdata[0], s_tdata[1]};
    key_down  = !s_tdata[2];
    step      = rdsc_pkg::STEP_NONE;
    leave     = 1'b0;
    leave_idx = '0;
    open      = 1'b0;
    poke      = 1'b0;

    last_phase_next     = last_phase;
    pending_step_next   = pending_step;
    key_was_down_next   = key_was_down;
    selection_next      = selection;
    focus_reported_next = focus_reported;

    since_scan_next  = (since_scan == '1) ? since_scan : since_scan + 8'd1;
    since_click_next = (since_click == '1) ? since_click : since_click + 10'd1;
    focus_left_next  = (focus_left == '0) ? focus_left : focus_left - 16'd1;

    if (since_scan_next >= scan_period) begin
      since_scan_next = '0;
      if (phase != last_phase) begin
        unique case (phase)
          rdsc_pkg::PHASE_10: begin
            if (last_phase == rdsc_pkg::PHASE_00) pending_step_next = rdsc_pkg::STEP_FWD;
            else if (last_phase == rdsc_pkg::PHASE_11) pending_step_next = rdsc_pkg::STEP_BWD;
          end
          rdsc_pkg::PHASE_01: begin
            if (last_phase == rdsc_pkg::PHASE_00) pending_step_next = rdsc_pkg::STEP_BWD;
            else if (last_phase == rdsc_pkg::PHASE_11) pending_step_next = rdsc_pkg::STEP_FWD;
          end
          default: begin
            // detent: commit the pending direction
            last_phase_next = phase;
            if (pending_step != rdsc_pkg::STEP_NONE) begin
              if (count != '0) begin
                if (pending_step == rdsc_pkg::STEP_FWD) begin
                  selection_next = (selection == last_index) ? '0 : selection + 3'd1;
                end else begin
                  selection_next = (selection == '0) ? last_index : selection - 3'd1;
                end
                step = pending_step;
                if (selection_next != selection) begin
                  leave     = 1'b1;
                  leave_idx = selection;
                end
                focus_left_next = focus_hold;
              end
              pending_step_next = rdsc_pkg::STEP_NONE;
            end
          end
        endcase
      end

      if (!key_down && key_was_down) begin
        if (focus_left_next != '0 && count != '0) begin
          if (since_click_next >= click_lockout) begin
            since_click_next = '0;
            open             = 1'b1;
            focus_left_next  = focus_hold;
          end
        end else begin
          poke = 1'b1;
        end
      end
      key_was_down_next = key_down;
    end

    focused = (focus_left_next != '0) && (count != '0);
    if (focused && !focus_reported) begin
      focus_reported_next = 1'b1;
    end else if (!focused && focus_reported) begin
      focus_reported_next = 1'b0;
      leave               = 1'b1;
      leave_idx           = selection_next;
    end

    result_next = {4'd0, poke, open, leave ? leave_idx : 3'd0, leave, step, focused,
                   selection_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= rdsc_pkg::ENTRY_COUNT_RST;
      scan_period    <= rdsc_pkg::SCAN_PERIOD_RST;
      focus_hold     <= rdsc_pkg::FOCUS_HOLD_RST;
      click_lockout  <= rdsc_pkg::CLICK_LOCKOUT_RST;
      last_phase     <= rdsc_pkg::PHASE_11;
      pending_step   <= rdsc_pkg::STEP_NONE;
      key_was_down   <= 1'b0;
      selection      <= '0;
      focus_left     <= '0;
      since_click    <= '0;
      since_scan     <= '0;
      focus_reported <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (in_fire) begin
        last_phase     <= last_phase_next;
        pending_step   <= pending_step_next;
        key_was_down   <= key_was_down_next;
        focus_left     <= focus_left_next;
        since_click    <= since_click_next;
        since_scan     <= since_scan_next;
        focus_reported <= focus_reported_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // clamp the selection into the new range
      if (cfg_clamp) begin
        selection <= (cfg_count == '0) ? '0 : rdsc_pkg::INDEX_W'(cfg_count - 4'd1);
      end else if (in_fire) begin
        selection <= selection_next;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rdsc_pkg::REG_ENTRY_COUNT:   entry_count   <= cfg_data[rdsc_pkg::COUNT_W-1:0];
          rdsc_pkg::REG_SCAN_PERIOD:   scan_period   <= cfg_data[rdsc_pkg::SCAN_W-1:0];
          rdsc_pkg::REG_FOCUS_HOLD:    focus_hold    <= cfg_data[rdsc_pkg::FOCUS_W-1:0];
          rdsc_pkg::REG_CLICK_LOCKOUT: click_lockout <= cfg_data[rdsc_pkg::CLICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= result_next;
    end
  end

endmodule

// ----- design/rdsc_checker.sv -----
module rdsc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [rdsc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  // a stalled transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output payload changed while stalled");

  // an empty output register never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output register");

  // a key release is either an open or a poke, never both
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
    else $error("open and poke in one transaction");

  // no leave, no index; no reserved step code
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6] || m_tdata[9:7] == 3'd0) && m_tdata[5:4] != 2'd3)
    else $error("bad leave index or step code");

  // an accepted tick shows up as a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted tick produced no result");

endmodule

bind rotary_dial_selection_controller rdsc_checker u_rdsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
